@@ sv/fir100_pkg.sv @@
`default_nettype none
package fir100_pkg;

    localparam int TAPS = 100;
    localparam int DEPTH = TAPS - 1;
    localparam int K_W = $clog2(TAPS);
    localparam int DA_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int SAMPLE_W = 16;
    localparam int COEF_W = 16;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_MIN_W = 37;
    localparam int ACC_W = (PROD_W + K_W > ACC_MIN_W) ? PROD_W + K_W : ACC_MIN_W;
    localparam int OUT_W = 25;
    localparam int DROP_BITS = 12;

    localparam int NUM_COEF = 100;
    localparam int CI_W = $clog2(NUM_COEF);

    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_coef COEF_TABLE [NUM_COEF] = '{
        16'sd492,   16'sd18432, 16'sd13517, 16'sd6144,  16'sd3686,
        16'sd11469, 16'sd16794, 16'sd15155, 16'sd9011,  16'sd5734,
        16'sd2458,  16'sd20480, 16'sd17613, 16'sd3277,  16'sd11878,
        16'sd14336, 16'sd4915,  16'sd1638,  16'sd11059, 16'sd6554,
        16'sd19661, 16'sd10240, 16'sd15974, 16'sd2867,  16'sd0,
        16'sd9421,  16'sd7373,  16'sd819,   16'sd13926, 16'sd19251,
        16'sd7782,  16'sd10650, 16'sd1229,  16'sd15565, 16'sd4506,
        16'sd16384, 16'sd8602,  16'sd13107, 16'sd5325,  16'sd2048,
        16'sd18022, 16'sd9830,  16'sd0,     16'sd3686,  16'sd18842,
        16'sd6963,  16'sd3277,  16'sd14746, 16'sd8192,  16'sd20070,
        16'sd5734,  16'sd2867,  16'sd11878, 16'sd5325,  16'sd17203,
        16'sd13517, 16'sd10650, 16'sd2458,  16'sd15565, 16'sd4096,
        16'sd19251, 16'sd10240, 16'sd1638,  16'sd15974, 16'sd4915,
        16'sd16384, 16'sd11059, 16'sd7373,  16'sd1229,  16'sd18022,
        16'sd9011,  16'sd13926, 16'sd6144,  16'sd19661, 16'sd410,
        16'sd12698, 16'sd8192,  16'sd20070, 16'sd6554,  16'sd15155,
        16'sd819,   16'sd18842, 16'sd9421,  16'sd14336, 16'sd6963,
        16'sd17613, 16'sd2048,  16'sd12288, 16'sd8602,  16'sd16794,
        16'sd5734,  16'sd3686,  16'sd11469, 16'sd14746, 16'sd18432,
        16'sd5325,  16'sd15974, 16'sd9830,  16'sd3277,  16'sd19251
    };

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    function automatic t_coef coef_at(input logic [K_W-1:0] k);
        t_coef c;
        c = '0;
        if (int'(k) < NUM_COEF) begin
            c = COEF_TABLE[CI_W'(k)];
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ sv/fir100_ram.sv @@
`default_nettype none
module fir100_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 99,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ sv/fir100_mac.sv @@
`default_nettype none
module fir100_mac (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire fir100_pkg::t_mac_ctl                   i_ctl,
    input  wire logic signed [fir100_pkg::COEF_W-1:0]   i_coef,
    input  wire logic signed [fir100_pkg::SAMPLE_W-1:0] i_data,
    output logic                                        o_done,
    output logic signed [fir100_pkg::OUT_W-1:0]         o_result
);

    localparam int SUM_W = fir100_pkg::ACC_W + 1;
    localparam int Q_W = SUM_W - fir100_pkg::DROP_BITS;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(2 ** (fir100_pkg::OUT_W - 1) - 1);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(2 ** (fir100_pkg::DROP_BITS - 1));

    fir100_pkg::t_mac_ctl r_a_ctl;
    logic signed [fir100_pkg::PROD_W-1:0] r_prod;
    logic signed [fir100_pkg::ACC_W-1:0] r_acc;
    logic signed [fir100_pkg::ACC_W-1:0] n_acc;
    logic signed [fir100_pkg::ACC_W-1:0] prod_ext;
    logic r_b_last;
    logic r_done;
    logic signed [fir100_pkg::OUT_W-1:0] r_result;
    logic signed [fir100_pkg::OUT_W-1:0] n_result;
    logic signed [SUM_W-1:0] rounded;
    logic signed [Q_W-1:0] q;

    assign prod_ext = fir100_pkg::ACC_W'(r_prod);

    always_comb begin
        n_acc = r_a_ctl.first ? prod_ext : r_acc + prod_ext;
    end

    always_comb begin
        rounded = SUM_W'(r_acc) + HALF;
        q = Q_W'(rounded >>> fir100_pkg::DROP_BITS);
        priority if (q > Q_MAX) begin
            n_result = fir100_pkg::OUT_W'(Q_MAX);
        end else if (q < Q_MIN) begin
            n_result = fir100_pkg::OUT_W'(Q_MIN);
        end else begin
            n_result = fir100_pkg::OUT_W'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_last <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_a_ctl <= i_ctl;
            r_b_last <= r_a_ctl.valid && r_a_ctl.last;
            r_done <= r_b_last;
        end
        r_prod <= i_coef * i_data;
        if (r_a_ctl.valid) begin
            r_acc <= n_acc;
        end
        if (r_b_last) begin
            r_result <= n_result;
        end
    end

    assign o_done = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire

@@ sv/fir_filter_100_tap.sv @@
// Direct-form FIR filter with fixed Q4.12 coefficients. Each item takes a
// Q1.15 sample and returns one saturated Q10.15 output. A single multiplier
// and accumulator visit the taps one per cycle, with the past samples read
// from a circular buffer in RAM, so an item occupies the block from acceptance
// until its result is passed to the output register, and no new item is taken
// before then. The finished output waits in its own register, so the next
// item may start while it is still pending. Samples before reset or
// before a start-of-stream flag count as zero.
`default_nettype none
module fir_filter_100_tap (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic signed [fir100_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                   i_start_of_stream,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic signed [fir100_pkg::OUT_W-1:0]         o_filtered
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    localparam logic [fir100_pkg::K_W-1:0] K_LAST = fir100_pkg::K_W'(fir100_pkg::TAPS - 1);
    localparam logic [fir100_pkg::DA_W-1:0] ADDR_LAST =
        fir100_pkg::DA_W'(fir100_pkg::DEPTH - 1);
    localparam logic [fir100_pkg::CNT_W-1:0] CNT_FULL =
        fir100_pkg::CNT_W'(fir100_pkg::DEPTH);

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic use_x;
        logic zero;
    } t_issue;

    logic [1:0] r_state, n_state;
    logic [fir100_pkg::K_W-1:0] r_k, n_k;
    logic [fir100_pkg::K_W-1:0] r_iss_k;
    logic [fir100_pkg::DA_W-1:0] r_addr, n_addr;
    logic [fir100_pkg::DA_W-1:0] r_ptr, n_ptr;
    logic [fir100_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic signed [fir100_pkg::SAMPLE_W-1:0] r_x;
    t_issue r_iss, n_iss;
    logic r_out_valid, n_out_valid;
    logic signed [fir100_pkg::OUT_W-1:0] r_out;
    logic signed [fir100_pkg::OUT_W-1:0] r_res;

    logic accept;
    logic rd_en;
    logic wr_en;
    logic [fir100_pkg::SAMPLE_W-1:0] rd_data;
    logic signed [fir100_pkg::SAMPLE_W-1:0] mac_data;
    fir100_pkg::t_mac_ctl mac_ctl;
    logic mac_done;
    logic signed [fir100_pkg::OUT_W-1:0] mac_result;
    logic out_free;

    assign o_ready = (r_state == S_IDLE);
    assign accept = i_valid && o_ready;
    assign rd_en = (r_state == S_RUN) && (r_k != '0);
    assign wr_en = (r_state == S_DRAIN) && mac_done;
    assign out_free = !r_out_valid || i_ready;

    fir100_ram #(
        .WIDTH(fir100_pkg::SAMPLE_W),
        .DEPTH(fir100_pkg::DEPTH)
    ) u_delay (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_ptr),
        .i_wdata(r_x),
        .i_re   (rd_en),
        .i_raddr(r_addr),
        .o_rdata(rd_data)
    );

    always_comb begin
        mac_ctl.valid = r_iss.valid;
        mac_ctl.first = r_iss.first;
        mac_ctl.last = r_iss.last;
        if (r_iss.use_x) begin
            mac_data = r_x;
        end else if (r_iss.zero) begin
            mac_data = '0;
        end else begin
            mac_data = $signed(rd_data);
        end
    end

    fir100_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_coef  (fir100_pkg::coef_at(r_iss_k)),
        .i_data  (mac_data),
        .o_done  (mac_done),
        .o_result(mac_result)
    );

    always_comb begin
        n_state = r_state;
        n_k = r_k;
        n_addr = r_addr;
        n_ptr = r_ptr;
        n_cnt = r_cnt;
        n_iss = '0;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RUN;
                    n_k = '0;
                    n_addr = (r_ptr == '0) ? ADDR_LAST : r_ptr - 1'b1;
                    if (i_start_of_stream) begin
                        n_cnt = '0;
                    end
                end
            end
            S_RUN: begin
                n_iss.valid = 1'b1;
                n_iss.first = (r_k == '0);
                n_iss.last = (r_k == K_LAST);
                n_iss.use_x = (r_k == '0);
                n_iss.zero = int'(r_k) > int'(r_cnt);
                if (r_k != '0) begin
                    n_addr = (r_addr == '0) ? ADDR_LAST : r_addr - 1'b1;
                end
                if (r_k == K_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (mac_done) begin
                    n_state = S_HOLD;
                    n_ptr = (r_ptr == ADDR_LAST) ? '0 : r_ptr + 1'b1;
                    if (r_cnt != CNT_FULL) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr <= '0;
            r_cnt <= '0;
            r_iss <= '0;
            r_out_valid <= 1'b0;
            r_k <= '0;
            r_addr <= '0;
        end else begin
            r_state <= n_state;
            r_ptr <= n_ptr;
            r_cnt <= n_cnt;
            r_iss <= n_iss;
            r_out_valid <= n_out_valid;
            r_k <= n_k;
            r_addr <= n_addr;
        end
        r_iss_k <= r_k;
        if (accept) begin
            r_x <= i_sample;
        end
        if (wr_en) begin
            r_res <= mac_result;
        end
        if ((r_state == S_HOLD) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_filtered = r_out;

endmodule
`default_nettype wire
